// ----- rtl/swlc_pkg.sv -----
// ----------------------------------------------------------------------------
// swlc_pkg
// Shared types and constants for the write-back LRU sector cache controller.
// ----------------------------------------------------------------------------
package swlc_pkg;

	localparam int SLOTS_DEF    = 4;
	localparam int MAX_RESULTS  = 5;
	// write-backs allowed per flush request, the done result takes the last place
	localparam int FLUSH_WB_MAX = MAX_RESULTS - 1;

	// request kinds
	localparam logic [1:0] FN_READ  = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_FLUSH = 2'd2;
	localparam logic [1:0] FN_PURGE = 2'd3;

	typedef enum logic [2:0] {
		ACT_DONE     = 3'd0,
		ACT_WB       = 3'd1,
		ACT_FETCH    = 3'd2,
		ACT_BYP_RD   = 3'd3,
		ACT_BYP_WR   = 3'd4,
		ACT_FLUSH_WB = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BYPASS,
		ST_SCAN,
		ST_RESOLVE,
		ST_EVICT,
		ST_FETCH,
		ST_DONE,
		ST_FL_NEXT,
		ST_FL_EVAL
	} state_t;

	// one command result
	typedef struct packed {
		action_t     action;
		logic [31:0] sector;
		logic [1:0]  slot;
		logic [7:0]  count;
		logic        last;
	} res_t;

	// tag store port controls
	typedef struct packed {
		logic rd_en;
		logic tag_we;
		logic ds_we;
	} mem_cmd_t;

endpackage

// ----- rtl/sector_writeback_lru_cache_top.sv -----
// ----------------------------------------------------------------------------
// sector_writeback_lru_cache_top
// Tag and policy controller of a fully associative write-back sector cache
// with LRU replacement. Emits writeback / fetch / bypass / done commands.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid, in_stall  | func, sector, count, now_tick, flush_age
//  out     | out_valid, out_stall| action, sector_out, slot, count_out, last
//
//  Sequencing: one request at a time. For a single-sector read or write
//  the single read port of the tag store walks every slot (hit and LRU
//  age in one pass; free slots come from the valid flags in flops).
//  A flush reads and checks its dirty candidate slots one by one.
//  Reset: valid and dirty flags clear at once; tag store needs no clearing.
//  Stalls: results sit in an output register, so the next request is taken
//  while the last result of the previous one waits for its transfer.
//
module sector_writeback_lru_cache_top #(
	parameter int SLOTS = swlc_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] sector,
	input  logic [7:0]  count,
	input  logic [31:0] now_tick,
	input  logic [31:0] flush_age,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [31:0] sector_out,
	output logic [1:0]  slot,
	output logic [7:0]  count_out,
	output logic        last
);

	localparam int IW = $clog2(SLOTS);

	swlc_pkg::mem_cmd_t mem_cmd;
	logic [IW-1:0]      rd_addr;
	logic [IW-1:0]      wr_addr;
	logic [31:0]        wr_sector;
	logic [31:0]        wr_time;
	logic [31:0]        rd_sector;
	logic [31:0]        rd_last_use;
	logic [31:0]        rd_dirty_since;
	logic               push;
	logic               push_ok;
	swlc_pkg::res_t     res;

	// per-slot tags and timestamps, read-modify-write by the sequencer;
	// reads and the commit write never fall in the same cycle
	swlc_tag_store #(
		.SLOTS(SLOTS)
	) u_store (
		.clk           (clk),
		.cmd           (mem_cmd),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_sector     (wr_sector),
		.wr_time       (wr_time),
		.rd_sector     (rd_sector),
		.rd_last_use   (rd_last_use),
		.rd_dirty_since(rd_dirty_since)
	);

	// request sequencer with valid/dirty flags
	swlc_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.sector        (sector),
		.count         (count),
		.now_tick      (now_tick),
		.flush_age     (flush_age),
		.mem_cmd       (mem_cmd),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.wr_sector     (wr_sector),
		.wr_time       (wr_time),
		.rd_sector     (rd_sector),
		.rd_last_use   (rd_last_use),
		.rd_dirty_since(rd_dirty_since),
		.push_ok       (push_ok),
		.push          (push),
		.res           (res)
	);

	// result register toward the out channel
	swlc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.push_ok   (push_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.action    (action),
		.sector_out(sector_out),
		.slot      (slot),
		.count_out (count_out),
		.last      (last)
	);

endmodule

// ----- rtl/swlc_tag_store.sv -----
// ----------------------------------------------------------------------------
// swlc_tag_store
// Per-slot storage: sector tag with last-use tick, and dirty-since tick.
// One read port with registered data, one write port.
// ----------------------------------------------------------------------------
module swlc_tag_store #(
	parameter int SLOTS = swlc_pkg::SLOTS_DEF,
	localparam int IW   = $clog2(SLOTS)
) (
	input  logic               clk,
	input  swlc_pkg::mem_cmd_t cmd,
	input  logic [IW-1:0]      rd_addr,
	input  logic [IW-1:0]      wr_addr,
	input  logic [31:0]        wr_sector,
	input  logic [31:0]        wr_time,
	output logic [31:0]        rd_sector,
	output logic [31:0]        rd_last_use,
	output logic [31:0]        rd_dirty_since
);

	logic [63:0] tag_mem [SLOTS];
	logic [31:0] ds_mem  [SLOTS];
	logic [63:0] rd_tag_q;
	logic [31:0] rd_ds_q;

	always_ff @(posedge clk) begin
		if (cmd.tag_we) begin
			tag_mem[wr_addr] <= {wr_sector, wr_time};
		end
		if (cmd.ds_we) begin
			ds_mem[wr_addr] <= wr_time;
		end
		if (cmd.rd_en) begin
			rd_tag_q <= tag_mem[rd_addr];
			rd_ds_q  <= ds_mem[rd_addr];
		end
	end

	assign rd_sector      = rd_tag_q[63:32];
	assign rd_last_use    = rd_tag_q[31:0];
	assign rd_dirty_since = rd_ds_q;

endmodule

// ----- rtl/swlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// swlc_ctrl
// Request sequencer: slot scan for hit / free / LRU victim, eviction,
// fetch, flush walk and purge. Holds valid and dirty flags in flops.
// ----------------------------------------------------------------------------
module swlc_ctrl #(
	parameter int SLOTS = swlc_pkg::SLOTS_DEF,
	localparam int IW   = $clog2(SLOTS),
	localparam int PW   = $clog2(SLOTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        sector,
	input  logic [7:0]         count,
	input  logic [31:0]        now_tick,
	input  logic [31:0]        flush_age,
	output swlc_pkg::mem_cmd_t mem_cmd,
	output logic [IW-1:0]      rd_addr,
	output logic [IW-1:0]      wr_addr,
	output logic [31:0]        wr_sector,
	output logic [31:0]        wr_time,
	input  logic [31:0]        rd_sector,
	input  logic [31:0]        rd_last_use,
	input  logic [31:0]        rd_dirty_since,
	input  logic               push_ok,
	output logic               push,
	output swlc_pkg::res_t     res
);

	swlc_pkg::state_t state_q, state_d;

	logic [1:0]       func_q;
	logic [31:0]      sector_q;
	logic [7:0]       count_q;
	logic [31:0]      now_q;
	logic [31:0]      age_q;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] dirty_q;
	logic [PW-1:0]    ptr_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic [31:0]      best_age_q;
	logic [IW-1:0]    best_idx_q;
	logic [31:0]      best_sec_q;
	logic [IW-1:0]    sel_q;
	logic [2:0]       wbn_q;

	logic             free_any;
	logic [IW-1:0]    free_idx;
	logic             cand_any;
	logic [IW-1:0]    cand_idx;
	logic [31:0]      age_scan;
	logic [31:0]      age_fl;
	logic             scan_hit;
	logic             scan_better;
	logic             fl_old;
	logic             is_rw;

	function automatic logic [1:0] slot2(input logic [IW-1:0] idx);
		logic [IW+1:0] w;
		w = {2'b00, idx};
		return w[1:0];
	endfunction

	// first free slot and next flush candidate, lowest index wins
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		cand_any = 1'b0;
		cand_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
			if (valid_q[i] && dirty_q[i] && (PW'(i) >= ptr_q)) begin
				cand_any = 1'b1;
				cand_idx = IW'(i);
			end
		end
	end

	assign age_scan    = now_q - rd_last_use;
	assign age_fl      = now_q - rd_dirty_since;
	assign scan_hit    = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_sector == sector_q) && !hit_q;
	assign scan_better = rd_vld_s1 && ((rd_idx_s1 == '0) || (age_scan > best_age_q));
	assign fl_old      = (age_fl >= age_q);
	assign is_rw       = (func_q == swlc_pkg::FN_READ) || (func_q == swlc_pkg::FN_WRITE);

	assign wr_addr   = sel_q;
	assign wr_sector = sector_q;
	assign wr_time   = now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swlc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = (state_q != swlc_pkg::ST_IDLE);
		mem_cmd     = '0;
		rd_addr     = ptr_q[IW-1:0];
		push        = 1'b0;
		res.action  = swlc_pkg::ACT_DONE;
		res.sector  = '0;
		res.slot    = '0;
		res.count   = '0;
		res.last    = 1'b0;
		unique case (state_q)
			swlc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = swlc_pkg::ST_DISPATCH;
				end
			end
			swlc_pkg::ST_DISPATCH: begin
				if (func_q == swlc_pkg::FN_PURGE) begin
					state_d = swlc_pkg::ST_DONE;
				end else if (func_q == swlc_pkg::FN_FLUSH) begin
					state_d = swlc_pkg::ST_FL_NEXT;
				end else if (count_q > 8'd1) begin
					state_d = swlc_pkg::ST_BYPASS;
				end else begin
					state_d = swlc_pkg::ST_SCAN;
				end
			end
			swlc_pkg::ST_BYPASS: begin
				res.action = (func_q == swlc_pkg::FN_READ) ? swlc_pkg::ACT_BYP_RD
				                                           : swlc_pkg::ACT_BYP_WR;
				res.sector = sector_q;
				res.count  = count_q;
				res.last   = 1'b1;
				push       = push_ok;
				if (push_ok) begin
					state_d = swlc_pkg::ST_IDLE;
				end
			end
			swlc_pkg::ST_SCAN: begin
				// read slot ptr while the previous slot's data is evaluated
				mem_cmd.rd_en = (ptr_q < PW'(SLOTS));
				if ((ptr_q == PW'(SLOTS)) && !rd_vld_s1) begin
					state_d = swlc_pkg::ST_RESOLVE;
				end
			end
			swlc_pkg::ST_RESOLVE: begin
				if (!hit_q && !free_any && dirty_q[best_idx_q]) begin
					state_d = swlc_pkg::ST_EVICT;
				end else if (!hit_q && (func_q == swlc_pkg::FN_READ)) begin
					state_d = swlc_pkg::ST_FETCH;
				end else begin
					state_d = swlc_pkg::ST_DONE;
				end
			end
			swlc_pkg::ST_EVICT: begin
				res.action = swlc_pkg::ACT_WB;
				res.sector = best_sec_q;
				res.slot   = slot2(sel_q);
				res.count  = 8'd1;
				push       = push_ok;
				if (push_ok) begin
					state_d = (func_q == swlc_pkg::FN_READ) ? swlc_pkg::ST_FETCH
					                                        : swlc_pkg::ST_DONE;
				end
			end
			swlc_pkg::ST_FETCH: begin
				res.action = swlc_pkg::ACT_FETCH;
				res.sector = sector_q;
				res.slot   = slot2(sel_q);
				res.count  = 8'd1;
				push       = push_ok;
				if (push_ok) begin
					state_d = swlc_pkg::ST_DONE;
				end
			end
			swlc_pkg::ST_DONE: begin
				res.last = 1'b1;
				if (is_rw) begin
					res.sector = sector_q;
					res.slot   = slot2(sel_q);
				end
				push = push_ok;
				if (push_ok) begin
					// commit the slot on the final transfer
					mem_cmd.tag_we = is_rw;
					mem_cmd.ds_we  = (func_q == swlc_pkg::FN_WRITE) && !dirty_q[sel_q];
					state_d        = swlc_pkg::ST_IDLE;
				end
			end
			swlc_pkg::ST_FL_NEXT: begin
				if ((wbn_q == 3'(swlc_pkg::FLUSH_WB_MAX)) || !cand_any) begin
					state_d = swlc_pkg::ST_DONE;
				end else begin
					mem_cmd.rd_en = 1'b1;
					rd_addr       = cand_idx;
					state_d       = swlc_pkg::ST_FL_EVAL;
				end
			end
			swlc_pkg::ST_FL_EVAL: begin
				if (fl_old) begin
					res.action = swlc_pkg::ACT_FLUSH_WB;
					res.sector = rd_sector;
					res.slot   = slot2(rd_idx_s1);
					res.count  = 8'd1;
					push       = push_ok;
					if (push_ok) begin
						state_d = swlc_pkg::ST_FL_NEXT;
					end
				end else begin
					state_d = swlc_pkg::ST_FL_NEXT;
				end
			end
			default: begin
				state_d = swlc_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			wbn_q     <= '0;
		end else begin
			rd_vld_s1 <= mem_cmd.rd_en;
			case (state_q)
				swlc_pkg::ST_DISPATCH: begin
					ptr_q <= '0;
					hit_q <= 1'b0;
					wbn_q <= '0;
					if (func_q == swlc_pkg::FN_PURGE) begin
						valid_q <= '0;
						dirty_q <= '0;
					end
				end
				swlc_pkg::ST_SCAN: begin
					if (mem_cmd.rd_en) begin
						ptr_q <= ptr_q + PW'(1);
					end
					if (scan_hit) begin
						hit_q <= 1'b1;
					end
				end
				swlc_pkg::ST_EVICT: begin
					if (push_ok) begin
						dirty_q[sel_q] <= 1'b0;
					end
				end
				swlc_pkg::ST_DONE: begin
					if (push_ok && is_rw) begin
						valid_q[sel_q] <= 1'b1;
						if (func_q == swlc_pkg::FN_WRITE) begin
							dirty_q[sel_q] <= 1'b1;
						end
					end
				end
				swlc_pkg::ST_FL_EVAL: begin
					if (fl_old) begin
						if (push_ok) begin
							dirty_q[rd_idx_s1] <= 1'b0;
							wbn_q              <= wbn_q + 3'd1;
							ptr_q              <= PW'(rd_idx_s1) + PW'(1);
						end
					end else begin
						ptr_q <= PW'(rd_idx_s1) + PW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (mem_cmd.rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if ((state_q == swlc_pkg::ST_IDLE) && in_valid) begin
			func_q   <= func;
			sector_q <= sector;
			count_q  <= count;
			now_q    <= now_tick;
			age_q    <= flush_age;
		end
		if (state_q == swlc_pkg::ST_SCAN) begin
			if (scan_hit) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (scan_better) begin
				best_age_q <= age_scan;
				best_idx_q <= rd_idx_s1;
				best_sec_q <= rd_sector;
			end
		end
		if (state_q == swlc_pkg::ST_RESOLVE) begin
			sel_q <= hit_q ? hit_idx_q : (free_any ? free_idx : best_idx_q);
		end
	end

endmodule

// ----- rtl/swlc_out_reg.sv -----
// ----------------------------------------------------------------------------
// swlc_out_reg
// Result output register; frees the sequencer while a result waits.
// ----------------------------------------------------------------------------
module swlc_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swlc_pkg::res_t res,
	output logic           push_ok,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     action,
	output logic [31:0]    sector_out,
	output logic [1:0]     slot,
	output logic [7:0]     count_out,
	output logic           last
);

	logic           valid_q;
	swlc_pkg::res_t res_q;

	assign push_ok = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign action     = res_q.action;
	assign sector_out = res_q.sector;
	assign slot       = res_q.slot;
	assign count_out  = res_q.count;
	assign last       = res_q.last;

endmodule
